// ----- sv/gsdp_pkg.sv -----
// ----------------------------------------------------------------------------
// gsdp_pkg
// Shared constants and types of the group scaled int8 dot product: the
// defaults of the top level parameters and the command that the front
// part hands to the back part.
// ----------------------------------------------------------------------------
package gsdp_pkg;

    localparam int SCALE_FRAC_BITS_DEF = 24;
    localparam int CMD_DEPTH_DEF       = 4;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic        group_end;
        logic        row_end;
        logic [31:0] group_sum;
        logic [31:0] act_scale;
        logic [31:0] weight_scale;
        logic [7:0]  bias_value;
        logic [31:0] bias_scale;
    } cmd_t;

endpackage

// ----- sv/gsdp_front.sv -----
// ----------------------------------------------------------------------------
// gsdp_front
// Takes one operand pair per cycle while the queue has room, keeps the exact
// integer group sum and issues a command to the back on each group or row end.
// ----------------------------------------------------------------------------
module gsdp_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        activation,
    input  logic [7:0]                        weight,
    input  logic [31:0]                       act_scale,
    input  logic [31:0]                       weight_scale,
    input  logic                              last_in_group,
    input  logic                              last_in_row,
    input  logic [7:0]                        bias_value,
    input  logic [31:0]                       bias_scale,
    output logic                              cmd_push,
    output gsdp_pkg::cmd_t                    cmd_data,
    input  logic                              cmd_full
);

    logic               accept;
    logic signed [15:0] pair_prod;
    logic [31:0]        sum_now;
    logic [31:0]        group_sum_reg;
    logic [31:0]        group_sum_next;

    assign in_ready  = !cmd_full;
    assign accept    = in_valid && in_ready;
    assign pair_prod = $signed(activation) * $signed(weight);
    assign sum_now   = group_sum_reg + {{16{pair_prod[15]}}, pair_prod};

    always_comb begin
        group_sum_next = group_sum_reg;
        if (accept) begin
            group_sum_next = (last_in_group || last_in_row) ? 32'd0 : sum_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sum_reg <= '0;
        end else begin
            group_sum_reg <= group_sum_next;
        end
    end

    assign cmd_push               = accept && (last_in_group || last_in_row);
    assign cmd_data.group_end     = last_in_group;
    assign cmd_data.row_end       = last_in_row;
    assign cmd_data.group_sum     = sum_now;
    assign cmd_data.act_scale     = act_scale;
    assign cmd_data.weight_scale  = weight_scale;
    assign cmd_data.bias_value    = bias_value;
    assign cmd_data.bias_scale    = bias_scale;

endmodule

// ----- sv/gsdp_fifo.sv -----
// ----------------------------------------------------------------------------
// gsdp_fifo
// Small command queue in flip-flops between the front and back parts.
// ----------------------------------------------------------------------------
module gsdp_fifo #(
    parameter int DEPTH = gsdp_pkg::CMD_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gsdp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output gsdp_pkg::cmd_t pop_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsdp_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/gsdp_back.sv -----
// ----------------------------------------------------------------------------
// gsdp_back
// Carries out group and row commands: scales the group sum by both scales
// over split 32-bit multiplies, rounds, clamps, adds with saturation into the
// Q47.16 row accumulator, adds the bias if enabled and emits the row value.
// ----------------------------------------------------------------------------
module gsdp_back #(
    parameter int SCALE_FRAC_BITS = gsdp_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           bias_enable,
    input  logic           cmd_empty,
    input  gsdp_pkg::cmd_t cmd_data,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    out_value,
    output logic           out_saturated
);

    localparam int SH_G     = 2 * SCALE_FRAC_BITS - 16;
    localparam int SH_B     = (SCALE_FRAC_BITS >= 16) ? SCALE_FRAC_BITS - 16 : 0;
    localparam int BIAS_LSH = (SCALE_FRAC_BITS < 16) ? 16 - SCALE_FRAC_BITS : 0;
    localparam int BSW      = 32 + BIAS_LSH;

    localparam logic [96:0] RND_G = (97'd1 << SH_G) >> 1;
    localparam logic [96:0] RND_B = (97'd1 << SH_B) >> 1;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SMUL = 4'd1;
    localparam logic [3:0] ST_P0   = 4'd2;
    localparam logic [3:0] ST_P1   = 4'd3;
    localparam logic [3:0] ST_RND  = 4'd4;
    localparam logic [3:0] ST_ACC  = 4'd5;
    localparam logic [3:0] ST_ROW  = 4'd6;
    localparam logic [3:0] ST_EMIT = 4'd7;

    logic [3:0]     state_reg, state_next;
    gsdp_pkg::cmd_t cmd_reg, cmd_next;
    logic [63:0]    scale_reg, scale_next;
    logic [31:0]    mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [63:0]    p0_reg, p0_next;
    logic [95:0]    prod_reg, prod_next;
    logic           bias_phase_reg, bias_phase_next;
    logic [63:0]    term_reg, term_next;
    logic           term_ov_reg, term_ov_next;
    logic [63:0]    row_sum_reg, row_sum_next;
    logic           row_ov_reg, row_ov_next;
    logic           out_valid_reg, out_valid_next;
    logic [63:0]    out_value_reg, out_value_next;
    logic           out_sat_reg, out_sat_next;

    logic [63:0]    p1;
    logic [96:0]    rnd;
    logic [96:0]    shifted;
    logic [63:0]    limit;
    logic           rnd_ov;
    logic [63:0]    add_sum;
    logic           add_ov;
    logic [7:0]     bias_mag;
    logic [BSW-1:0] bias_s;
    logic [BSW+7:0] bias_prod;
    logic           emit_ok;

    assign p1        = mag_reg * scale_reg[63:32];
    assign rnd       = {1'b0, prod_reg} + (bias_phase_reg ? RND_B : RND_G);
    assign shifted   = bias_phase_reg ? (rnd >> SH_B) : (rnd >> SH_G);
    assign limit     = neg_reg ? NEG_MIN : POS_MAX;
    assign rnd_ov    = (shifted[96:64] != '0) || (shifted[63:0] > limit);
    assign add_sum   = row_sum_reg + term_reg;
    assign add_ov    = (row_sum_reg[63] == term_reg[63]) && (add_sum[63] != row_sum_reg[63]);
    assign bias_mag  = cmd_reg.bias_value[7] ? (~cmd_reg.bias_value + 8'd1)
                                             : cmd_reg.bias_value;
    assign bias_s    = BSW'(cmd_reg.bias_scale) << BIAS_LSH;
    assign bias_prod = bias_mag * bias_s;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign cmd_pop   = (state_reg == ST_IDLE) && !cmd_empty;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scale_next      = scale_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        p0_next         = p0_reg;
        prod_next       = prod_reg;
        bias_phase_next = bias_phase_reg;
        term_next       = term_reg;
        term_ov_next    = term_ov_reg;
        row_sum_next    = row_sum_reg;
        row_ov_next     = row_ov_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_sat_next    = out_sat_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_next   = cmd_data;
                    state_next = cmd_data.group_end ? ST_SMUL : ST_ROW;
                end
            end
            ST_SMUL: begin
                scale_next      = cmd_reg.act_scale * cmd_reg.weight_scale;
                neg_next        = cmd_reg.group_sum[31];
                mag_next        = cmd_reg.group_sum[31] ? (~cmd_reg.group_sum + 32'd1)
                                                        : cmd_reg.group_sum;
                bias_phase_next = 1'b0;
                state_next      = ST_P0;
            end
            ST_P0: begin
                p0_next    = mag_reg * scale_reg[31:0];
                state_next = ST_P1;
            end
            ST_P1: begin
                prod_next  = {32'd0, p0_reg} + {p1, 32'd0};
                state_next = ST_RND;
            end
            ST_RND: begin
                term_ov_next = rnd_ov;
                if (rnd_ov) begin
                    term_next = neg_reg ? NEG_MIN : POS_MAX;
                end else begin
                    term_next = neg_reg ? (~shifted[63:0] + 64'd1) : shifted[63:0];
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                row_sum_next = add_ov ? (row_sum_reg[63] ? NEG_MIN : POS_MAX) : add_sum;
                row_ov_next  = row_ov_reg || term_ov_reg || add_ov;
                if (bias_phase_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = cmd_reg.row_end ? ST_ROW : ST_IDLE;
                end
            end
            ST_ROW: begin
                if (bias_enable) begin
                    prod_next       = 96'(bias_prod);
                    neg_next        = cmd_reg.bias_value[7];
                    bias_phase_next = 1'b1;
                    state_next      = ST_RND;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    out_valid_next = 1'b1;
                    out_value_next = row_sum_reg;
                    out_sat_next   = row_ov_reg;
                    row_sum_next   = '0;
                    row_ov_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_sum_reg   <= '0;
            row_ov_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_sum_reg   <= row_sum_next;
            row_ov_reg    <= row_ov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        scale_reg      <= scale_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        p0_reg         <= p0_next;
        prod_reg       <= prod_next;
        bias_phase_reg <= bias_phase_next;
        term_reg       <= term_next;
        term_ov_reg    <= term_ov_next;
        out_value_reg  <= out_value_next;
        out_sat_reg    <= out_sat_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_saturated = out_sat_reg;

endmodule

// ----- sv/group_scaled_int8_dot_product.sv -----
// ----------------------------------------------------------------------------
// group_scaled_int8_dot_product
// Int8 dot product with per-group Q8.24 scales, a Q47.16 saturating row
// accumulator and an optional scaled bias at row end.
//
//   channel  direction  handshake               carries
//   s_       in         s_tvalid / s_tready     one operand pair with scales
//   m_       out        m_tvalid / m_tready     one row value per row end
//   cfg_     in         cfg_valid / cfg_ready   bias_enable
//
// The front takes one item per cycle while s_tready is high, updating the
// group sum in that cycle. A group end costs the back pop, scale product,
// two split 32x32 multiplies, round and add; a row end adds a row step, round
// and add with bias, emit, and a pop if it closes no group. A 4-entry command
// queue absorbs these; s_tready falls only when it fills. Synchronous reset
// on aresetn low clears all accumulators; m_tready low stalls the next emit.
// ----------------------------------------------------------------------------
module group_scaled_int8_dot_product #(
    parameter int SCALE_FRAC_BITS = gsdp_pkg::SCALE_FRAC_BITS_DEF,
    parameter int CMD_DEPTH       = gsdp_pkg::CMD_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // activation[7:0], weight[15:8], act_scale[47:16], weight_scale[79:48],
    // bias_value[87:80], bias_scale[119:88]
    input  logic [gsdp_pkg::S_TDATA_W-1:0]     s_tdata,
    // last_in_group[0]
    input  logic [0:0]                         s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row_value[63:0]
    output logic [gsdp_pkg::M_TDATA_W-1:0]     m_tdata,
    // saturated[0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_data
);

    logic           bias_en_reg;
    logic           bias_en_next;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_full;
    logic           cmd_empty;
    gsdp_pkg::cmd_t cmd_in;
    gsdp_pkg::cmd_t cmd_out;
    logic           saturated;

    assign cfg_ready    = 1'b1;
    assign bias_en_next = (cfg_valid && cfg_ready) ? cfg_data[0] : bias_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_en_reg <= 1'b0;
        end else begin
            bias_en_reg <= bias_en_next;
        end
    end

    gsdp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .activation    (s_tdata[7:0]),
        .weight        (s_tdata[15:8]),
        .act_scale     (s_tdata[47:16]),
        .weight_scale  (s_tdata[79:48]),
        .last_in_group (s_tuser[0]),
        .last_in_row   (s_tlast),
        .bias_value    (s_tdata[87:80]),
        .bias_scale    (s_tdata[119:88]),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in),
        .cmd_full      (cmd_full)
    );

    gsdp_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    gsdp_back #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bias_enable   (bias_en_reg),
        .cmd_empty     (cmd_empty),
        .cmd_data      (cmd_out),
        .cmd_pop       (cmd_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_value     (m_tdata),
        .out_saturated (saturated)
    );

    assign m_tuser[0] = saturated;

endmodule
